// ----- rtl/core/mdio_pkg.sv -----
// Shared constants and PHY preload tables for the MDIO master register model.
`default_nettype none

package mdio_pkg;

  localparam int unsigned NUM_PHYS     = 32;
  localparam int unsigned REGS_PER_PHY = 32;

  localparam int unsigned PHY_AW     = $clog2(NUM_PHYS);
  localparam int unsigned REG_AW     = $clog2(REGS_PER_PHY);
  localparam int unsigned FILE_AW    = PHY_AW + REG_AW;
  localparam int unsigned FILE_DEPTH = 1 << FILE_AW;
  localparam int unsigned MMD_DEPTH  = 1 << PHY_AW;

  // Command word bit positions.
  localparam int unsigned BIT_BUSY = 29;
  localparam int unsigned BIT_FAIL = 28;
  localparam int unsigned BIT_RD   = 27;
  localparam int unsigned BIT_WR   = 26;

  localparam logic [4:0] REG_MMD_CTRL = 5'd13;
  localparam logic [4:0] REG_MMD_DATA = 5'd14;

  localparam logic [4:0]  MMD_DEV_COPPER = 5'h1e;
  localparam logic [15:0] MMD_AD_COPPER  = 16'h400d;
  localparam logic [4:0]  MMD_DEV_AUX    = 5'h07;
  localparam logic [15:0] MMD_AD_AUX     = 16'hfff9;

  localparam logic [31:0] ID_GPHY  = 32'h359050e0;
  localparam logic [31:0] ID_XPHY  = 32'h359050e1;
  localparam logic [31:0] ID_EPHY  = 32'h35905081;
  localparam logic [15:0] INIT_BMSR = 16'h796d;
  localparam logic [15:0] INIT_BMCR = 16'h1000;
  localparam logic [15:0] XPHY_COPPER_STATUS = 16'h0038;
  localparam logic [15:0] XPHY_AUX_STATUS    = 16'h0200;
  localparam logic [15:0] DATA_ABSENT        = 16'hffff;

  function automatic logic [31:0] phy_id(input logic [4:0] pa);
    logic [31:0] id;
    id = 32'd0;
    case (pa)
      5'd1, 5'd2, 5'd3, 5'd4: id = ID_GPHY;
      5'd9:                   id = ID_XPHY;
      5'd21:                  id = ID_EPHY;
      default:                id = 32'd0;
    endcase
    return id;
  endfunction

  function automatic logic phy_here(input logic [4:0] pa);
    return (32'(pa) < NUM_PHYS) && (phy_id(pa) != 32'd0);
  endfunction

  function automatic logic reg_in_range(input logic [4:0] rg);
    return 32'(rg) < REGS_PER_PHY;
  endfunction

  function automatic logic [15:0] copper_status(input logic [4:0] pa);
    return (phy_here(pa) && phy_id(pa) == ID_XPHY) ? XPHY_COPPER_STATUS : 16'd0;
  endfunction

  function automatic logic [15:0] aux_status(input logic [4:0] pa);
    return (phy_here(pa) && phy_id(pa) == ID_XPHY) ? XPHY_AUX_STATUS : 16'd0;
  endfunction

  // Reset contents of one register file entry.
  function automatic logic [15:0] preload(input logic [4:0] pa, input logic [4:0] rg);
    logic [31:0] id;
    logic [15:0] v;
    id = phy_id(pa);
    v  = 16'd0;
    if (phy_here(pa)) begin
      case (rg)
        5'd0:    v = INIT_BMCR;
        5'd1:    v = INIT_BMSR;
        5'd2:    v = id[31:16];
        5'd3:    v = id[15:0];
        default: v = 16'd0;
      endcase
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mdio_master_phy_register_model.sv -----
// Top level: MDIO master command/config words with a memory-backed PHY register model.
// A result beat is staged in res_q when its request is taken and is offered from
// out_data_q once the output register is free. No request is taken while a result
// is pending, so a held result stops the input. A command write that reaches a PHY
// reads the register file when taken and stores a write at the next edge.
// Reset: asynchronous, active low. After reset a preload pass walks the PHY
// register memory one entry a cycle (FILE_DEPTH entries, 1024 by default) and no
// request is taken until it finishes.
`default_nettype none

module mdio_master_phy_register_model (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic        reg_select_i,
  input  wire logic [31:0] write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      read_data_o
);
  import mdio_pkg::*;

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [FILE_AW-1:0] init_cnt_q;

  // The PHY register file, and a per-PHY MMD store holding {device, address}.
  logic [15:0] file_mem [FILE_DEPTH];
  logic [20:0] mmd_mem [MMD_DEPTH];
  logic [15:0] file_rdata_q;
  logic [20:0] mmd_rdata_q;

  logic [31:0] cmd_q, cmd_d;
  logic [31:0] cfg_q;
  logic [31:0] wrd_q;      // command word driving the pending PHY transaction
  logic        do_rd_q;    // pending transaction is a read, otherwise a write
  logic [31:0] res_q;
  logic        res_pend_q;
  logic        out_valid_q;
  logic [31:0] out_data_q;

  logic        acc, is_cmd_wr, use_v, go_mem, move;
  logic [31:0] wrd_sel;
  logic [4:0]  acc_pa, acc_rg;

  assign in_ready_o  = (state_q == ST_IDLE) && !res_pend_q;
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

  assign acc       = in_valid_i && in_ready_o;
  assign is_cmd_wr = req_type_i && !reg_select_i;
  assign use_v     = write_data_i[BIT_RD] || write_data_i[BIT_WR];
  assign go_mem    = is_cmd_wr && (use_v || cmd_q[BIT_RD]);
  assign wrd_sel   = use_v ? write_data_i : cmd_q;
  assign acc_pa    = wrd_sel[25:21];
  assign acc_rg    = wrd_sel[20:16];
  assign move      = res_pend_q && (!out_valid_q || out_ready_i);

  // Completion of the pending transaction, from the memory data read at accept.
  logic [4:0]  upd_pa, upd_rg;
  logic        upd_here;
  logic [15:0] rd_val;
  logic        file_we, mmd_we;
  logic [FILE_AW-1:0] file_waddr;
  logic [15:0] file_wdata;
  logic [PHY_AW-1:0] mmd_waddr;
  logic [20:0] mmd_wdata;

  assign upd_pa   = wrd_q[25:21];
  assign upd_rg   = wrd_q[20:16];
  assign upd_here = phy_here(upd_pa);

  always_comb begin
    rd_val = 16'd0;
    if (!upd_here) begin
      rd_val = DATA_ABSENT;
    end else if (upd_rg == REG_MMD_DATA) begin
      if (mmd_rdata_q[20:16] == MMD_DEV_COPPER && mmd_rdata_q[15:0] == MMD_AD_COPPER) begin
        rd_val = copper_status(upd_pa);
      end else if (mmd_rdata_q[20:16] == MMD_DEV_AUX && mmd_rdata_q[15:0] == MMD_AD_AUX) begin
        rd_val = aux_status(upd_pa);
      end
    end else if (reg_in_range(upd_rg)) begin
      rd_val = file_rdata_q;
    end
  end

  always_comb begin
    file_we    = 1'b0;
    file_waddr = init_cnt_q;
    file_wdata = preload(init_cnt_q[FILE_AW-1:REG_AW], 5'(init_cnt_q[REG_AW-1:0]));
    mmd_we     = 1'b0;
    mmd_waddr  = init_cnt_q[PHY_AW-1:0];
    mmd_wdata  = 21'd0;
    if (state_q == ST_INIT) begin
      file_we = 1'b1;
      // The MMD store is cleared during the first MMD_DEPTH entries of the pass.
      mmd_we  = (init_cnt_q[FILE_AW-1:PHY_AW] == '0);
    end else if (state_q == ST_UPD && !do_rd_q && upd_here) begin
      mmd_waddr  = upd_pa[PHY_AW-1:0];
      file_waddr = {upd_pa[PHY_AW-1:0], upd_rg[REG_AW-1:0]};
      file_wdata = wrd_q[15:0];
      if (upd_rg == REG_MMD_CTRL) begin
        mmd_we    = 1'b1;
        mmd_wdata = {wrd_q[4:0], mmd_rdata_q[15:0]};
      end else if (upd_rg == REG_MMD_DATA) begin
        mmd_we    = 1'b1;
        mmd_wdata = {mmd_rdata_q[20:16], wrd_q[15:0]};
      end else begin
        file_we = reg_in_range(upd_rg);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (file_we) begin
      file_mem[file_waddr] <= file_wdata;
    end
    if (mmd_we) begin
      mmd_mem[mmd_waddr] <= mmd_wdata;
    end
    if (acc) begin
      file_rdata_q <= file_mem[{acc_pa[PHY_AW-1:0], acc_rg[REG_AW-1:0]}];
      mmd_rdata_q  <= mmd_mem[acc_pa[PHY_AW-1:0]];
    end
  end

  // Next command word and sequencer state.
  always_comb begin
    cmd_d   = cmd_q;
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (init_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc && is_cmd_wr) begin
          if (go_mem) begin
            state_d = ST_UPD;
          end else begin
            cmd_d[BIT_BUSY] = 1'b0;
          end
        end
      end
      ST_UPD: begin
        state_d = ST_IDLE;
        if (do_rd_q) begin
          cmd_d           = {wrd_q[31:16], rd_val};
          cmd_d[BIT_BUSY] = 1'b0;
          if (!upd_here) begin
            cmd_d[BIT_FAIL] = 1'b1;
          end
        end else begin
          cmd_d           = wrd_q;
          cmd_d[BIT_BUSY] = 1'b0;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_cnt_q  <= '0;
      cmd_q       <= 32'd0;
      cfg_q       <= 32'd0;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      if (state_q == ST_INIT) begin
        init_cnt_q <= init_cnt_q + 1'b1;
      end
      if (acc && req_type_i && reg_select_i) begin
        cfg_q <= write_data_i;
      end
      res_pend_q <= (res_pend_q && !move) || acc;
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      wrd_q   <= wrd_sel;
      do_rd_q <= write_data_i[BIT_RD] || (!write_data_i[BIT_WR] && cmd_q[BIT_RD]);
      if (req_type_i) begin
        res_q <= 32'd0;
      end else if (reg_select_i) begin
        res_q <= cfg_q;
      end else begin
        res_q <= cmd_q & ~(32'd1 << BIT_BUSY);
      end
    end
    if (move) begin
      out_data_q <= res_q;
    end
  end

  // A command beat that reaches a PHY always enters the update cycle.
  a_mem_cmd_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && go_mem) |=> (state_q == ST_UPD))
    else $error("PHY transaction did not enter its update cycle");

  // The update state is always followed by idle.
  a_update_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |=> (state_q == ST_IDLE))
    else $error("update cycle did not return to idle");

  // Every accepted beat leaves a result held somewhere.
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (res_pend_q || out_valid_q))
    else $error("result of an accepted beat was lost");

endmodule

`default_nettype wire
